### src/device_class_allocator_assert.svh
// ---------------------------------------------------------------------------
// device class allocator assertion macros
// implication checks sampled on i_clk, off while i_rst_n is low
// ---------------------------------------------------------------------------
`ifndef DEVICE_CLASS_ALLOCATOR_ASSERT_SVH
`define DEVICE_CLASS_ALLOCATOR_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define DCA_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("allocator check failed in the same cycle");

// consequent must hold in the cycle after the antecedent
`define DCA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("allocator check failed in the next cycle");

`endif

### src/dca_pkg.sv
// ---------------------------------------------------------------------------
// dca_pkg
// shared types, codes and constants of the device class allocator
// ---------------------------------------------------------------------------
package dca_pkg;

    localparam int CFG_CLASSES = 4;
    localparam int CLS_W       = 2;
    localparam int BASE_W      = 4;
    localparam int COUNT_W     = 5;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 5;
    localparam int SCAN_W      = 7;
    localparam int JOB_W       = 16;
    localparam int REL_W       = 8;
    localparam int DEV_W       = 4;
    localparam int STATUS_W    = 3;

    // request kinds
    localparam logic KIND_ALLOC   = 1'b0;
    localparam logic KIND_RECLAIM = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_ALLOCATED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_RECLAIMED  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NO_CLASS   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NONE_FREE  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_HELD   = 3'd4;

    // class register reset values
    localparam logic [BASE_W-1:0]  BASE_RST  [CFG_CLASSES] = '{4'd0, 4'd2, 4'd5, 4'd9};
    localparam logic [COUNT_W-1:0] COUNT_RST [CFG_CLASSES] = '{5'd2, 5'd3, 5'd4, 5'd1};

    typedef struct packed {
        logic              kind;
        logic [2:0]        class_id;
        logic [JOB_W-1:0]  job_tag;
        logic [REL_W-1:0]  relative_number;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DEV_W-1:0]    device_number;
        logic [COUNT_W-1:0]  class_free;
    } t_res;

    // slot table update command
    typedef struct packed {
        logic set;
        logic clr;
    } t_slot_cmd;

endpackage

### src/dca_slot_table.sv
// ---------------------------------------------------------------------------
// dca_slot_table
// per-slot allocated flags, owning job tags and relative numbers
// ---------------------------------------------------------------------------
module dca_slot_table #(
    parameter int NUM_SLOTS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [$clog2(NUM_SLOTS)-1:0] i_addr,
    input  dca_pkg::t_slot_cmd           i_cmd,
    input  logic [dca_pkg::JOB_W-1:0]    i_job,
    input  logic [dca_pkg::REL_W-1:0]    i_rel,
    output logic                         o_allocated,
    output logic [dca_pkg::JOB_W-1:0]    o_job
);
    import dca_pkg::*;

    logic [NUM_SLOTS-1:0] r_alloc;
    logic [JOB_W-1:0]     r_job_mem [NUM_SLOTS];
    logic [REL_W-1:0]     r_rel_mem [NUM_SLOTS];
    logic [JOB_W-1:0]     r_job_rd;

    // allocated flags double as entry valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alloc <= '0;
        end else if (i_cmd.set) begin
            r_alloc[i_addr] <= 1'b1;
        end else if (i_cmd.clr) begin
            r_alloc[i_addr] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.set) begin
            r_job_mem[i_addr] <= i_job;
            r_rel_mem[i_addr] <= i_rel;
        end else if (i_cmd.clr) begin
            r_job_mem[i_addr] <= '0;
            r_rel_mem[i_addr] <= '0;
        end
        r_job_rd <= r_job_mem[i_addr];
    end

    assign o_allocated = r_alloc[i_addr];
    assign o_job       = r_job_rd;

endmodule

### src/device_class_allocator.sv
// ---------------------------------------------------------------------------
// device_class_allocator
// hands out and takes back device slots grouped in four configured classes
// ---------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy then stays high
// until the single result has been formed. The result appears on o_result for
// exactly one cycle with o_result_valid and cannot be held off; start may be
// raised again in that same cycle. One comparator and incrementer walk the
// class range one slot per step. An unknown class, or an allocate with nothing
// free by count, goes straight to the result without a scan. A reclaim visits
// each slot in S_SCAN and then S_CHECK because the job tag comes out of the
// slot table's registered read port. The class registers (index 2c base,
// 2c+1 count) are written through the cfg channel, which is always ready;
// writes beyond index 7 are dropped.
// ---------------------------------------------------------------------------
`include "device_class_allocator_assert.svh"

module device_class_allocator #(
    parameter int NUM_SLOTS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // request / result
    input  logic                            start,
    input  dca_pkg::t_req                   i_item,
    output logic                            busy,
    output logic                            o_result_valid,
    output dca_pkg::t_res                   o_result,
    // class register writes
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [dca_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [dca_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import dca_pkg::*;

    localparam int SLOT_W = $clog2(NUM_SLOTS);
    localparam logic [SCAN_W-1:0] L_NSLOT = SCAN_W'(NUM_SLOTS);

    // sequencer states
    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_CHECK  = 2'd2;
    localparam logic [1:0] S_RESULT = 2'd3;

    // class registers and per-class in-use counts
    logic [BASE_W-1:0]  r_base   [CFG_CLASSES];
    logic [COUNT_W-1:0] r_count  [CFG_CLASSES];
    logic [COUNT_W-1:0] r_in_use [CFG_CLASSES];
    logic [COUNT_W-1:0] n_in_use [CFG_CLASSES];

    // sequencer and latched request
    logic [1:0]          r_state, n_state;
    logic                r_kind, n_kind;
    logic [CLS_W-1:0]    r_cls, n_cls;
    logic                r_cls_ok, n_cls_ok;
    logic [JOB_W-1:0]    r_job, n_job;
    logic [REL_W-1:0]    r_rel, n_rel;
    logic [SCAN_W-1:0]   r_scan, n_scan;
    logic [SCAN_W-1:0]   r_end, n_end;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [DEV_W-1:0]    r_dev, n_dev;

    // result register
    logic                r_out_valid, n_out_valid;
    t_res                r_out, n_out;

    // request decode
    logic [CLS_W-1:0]    req_cls;
    logic                req_cls_ok;
    logic [SCAN_W-1:0]   req_sum;
    logic [SCAN_W-1:0]   req_end;
    logic [COUNT_W-1:0]  req_free;

    // slot table side
    logic [SLOT_W-1:0]   slot_idx;
    t_slot_cmd           slot_cmd;
    logic                slot_alloc;
    logic [JOB_W-1:0]    slot_job;
    logic                scan_end;

    function automatic logic [COUNT_W-1:0] free_of(input logic [COUNT_W-1:0] cnt,
                                                   input logic [COUNT_W-1:0] used);
        return (cnt > used) ? (cnt - used) : '0;
    endfunction

    assign busy           = (r_state != S_IDLE);
    assign o_cfg_ready    = 1'b1;
    assign o_result_valid = r_out_valid;
    assign o_result       = r_out;

    // class range of an incoming request, clipped at the table size
    assign req_cls    = i_item.class_id[CLS_W-1:0];
    assign req_cls_ok = (i_item.class_id < 3'(CFG_CLASSES));
    assign req_sum    = SCAN_W'(r_base[req_cls]) + SCAN_W'(r_count[req_cls]);
    assign req_end    = (req_sum > L_NSLOT) ? L_NSLOT : req_sum;
    assign req_free   = free_of(r_count[req_cls], r_in_use[req_cls]);

    // scan pointer addresses the table; scan_end marks it at or past the range end
    assign slot_idx = r_scan[SLOT_W-1:0];
    assign scan_end = (r_scan >= r_end);

    dca_slot_table #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_slots (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_addr      (slot_idx),
        .i_cmd       (slot_cmd),
        .i_job       (r_job),
        .i_rel       (r_rel),
        .o_allocated (slot_alloc),
        .o_job       (slot_job)
    );

    // sequencer: one slot compare per step
    always_comb begin
        n_state     = r_state;
        n_kind      = r_kind;
        n_cls       = r_cls;
        n_cls_ok    = r_cls_ok;
        n_job       = r_job;
        n_rel       = r_rel;
        n_scan      = r_scan;
        n_end       = r_end;
        n_status    = r_status;
        n_dev       = r_dev;
        n_in_use    = r_in_use;
        n_out_valid = 1'b0;
        n_out       = r_out;
        slot_cmd    = '0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_kind   = i_item.kind;
                    n_cls    = req_cls;
                    n_cls_ok = req_cls_ok;
                    n_job    = i_item.job_tag;
                    n_rel    = i_item.relative_number;
                    n_scan   = SCAN_W'(r_base[req_cls]);
                    n_end    = req_end;
                    n_dev    = '0;
                    if (!req_cls_ok) begin
                        n_status = ST_NO_CLASS;
                        n_state  = S_RESULT;
                    end else if (i_item.kind == KIND_ALLOC && req_free == '0) begin
                        // nothing free by count, no scan needed
                        n_status = ST_NONE_FREE;
                        n_state  = S_RESULT;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (scan_end) begin
                    n_status = (r_kind == KIND_ALLOC) ? ST_NONE_FREE : ST_NOT_HELD;
                    n_state  = S_RESULT;
                end else if (r_kind == KIND_RECLAIM) begin
                    // job tag read is in flight, compare next cycle
                    n_state = S_CHECK;
                end else if (!slot_alloc) begin
                    slot_cmd.set = 1'b1;
                    if (r_in_use[r_cls] != '1) begin
                        n_in_use[r_cls] = r_in_use[r_cls] + 1'b1;
                    end
                    n_status = ST_ALLOCATED;
                    n_dev    = r_scan[DEV_W-1:0];
                    n_state  = S_RESULT;
                end else begin
                    n_scan = r_scan + 1'b1;
                end
            end
            S_CHECK: begin
                if (slot_alloc && slot_job == r_job) begin
                    slot_cmd.clr = 1'b1;
                    if (r_in_use[r_cls] != '0) begin
                        n_in_use[r_cls] = r_in_use[r_cls] - 1'b1;
                    end
                    n_status = ST_RECLAIMED;
                    n_dev    = r_scan[DEV_W-1:0];
                    n_state  = S_RESULT;
                end else begin
                    n_scan  = r_scan + 1'b1;
                    n_state = S_SCAN;
                end
            end
            S_RESULT: begin
                // free count taken from the updated in-use count
                n_out_valid         = 1'b1;
                n_out.status        = r_status;
                n_out.device_number = r_dev;
                n_out.class_free    = r_cls_ok ? free_of(r_count[r_cls], r_in_use[r_cls])
                                               : '0;
                n_state             = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_in_use    <= '{default: '0};
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_in_use    <= n_in_use;
        end
    end

    // request and result payload
    always_ff @(posedge i_clk) begin
        r_kind   <= n_kind;
        r_cls    <= n_cls;
        r_cls_ok <= n_cls_ok;
        r_job    <= n_job;
        r_rel    <= n_rel;
        r_scan   <= n_scan;
        r_end    <= n_end;
        r_status <= n_status;
        r_dev    <= n_dev;
        r_out    <= n_out;
    end

    // class register writes: even index base, odd index count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= BASE_RST;
            r_count <= COUNT_RST;
        end else if (i_cfg_valid && o_cfg_ready && !i_cfg_index[CFG_IDX_W-1]) begin
            if (i_cfg_index[0]) begin
                r_count[i_cfg_index[CLS_W:1]] <= i_cfg_data[COUNT_W-1:0];
            end else begin
                r_base[i_cfg_index[CLS_W:1]] <= i_cfg_data[BASE_W-1:0];
            end
        end
    end

    // a result strobe never lasts more than one cycle
    `DCA_ASSERT_NEXT(a_strobe_single, r_out_valid, !r_out_valid)
    // an accepted item makes the block busy
    `DCA_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    // the job compare only ever looks at a slot inside the class range
    `DCA_ASSERT_SAME(a_check_in_range, r_state == S_CHECK, r_scan < r_end)

endmodule

### tb/device_class_allocator_test.sv
// ---------------------------------------------------------------------------
// device_class_allocator_test
// self-checking bench for the device class allocator: a short directed run on
// the reset class map, then phases of random allocate and reclaim items under
// rewritten class registers, each result checked against a mirror of the slot
// table that is updated as every item is taken
// ---------------------------------------------------------------------------
module device_class_allocator_test;
    timeunit 1ns;
    timeprecision 1ps;

    import dca_pkg::*;

    localparam int SLOTS           = 16;
    localparam int CLK_HALF        = 6;
    localparam int RST_CYCLES      = 10;
    // worst item is a full reclaim walk plus a long idle gap, over ~1350
    // items; several times that total
    localparam int CYCLE_LIMIT     = 600000;
    // longest reclaim walk plus margin
    localparam int DRAIN_CYCLES    = 2 * SLOTS + 8;
    localparam int PHASES          = 10;
    localparam int ITEMS_PER_PHASE = 133;
    localparam int REG_COUNT       = 2 * CFG_CLASSES;
    localparam int POOL_SIZE       = 6;
    localparam int REPORT_LIMIT    = 10;

    // two hand-picked class maps: full overlap, clipping at the top slot,
    // empty classes and single-slot classes
    localparam int EXT_BASE  [2][CFG_CLASSES] = '{'{0, 15, 0, 8}, '{15, 0, 4, 12}};
    localparam int EXT_COUNT [2][CFG_CLASSES] = '{'{16, 16, 0, 8}, '{1, 1, 16, 0}};

    // -----------------------------------------------------------------------
    // scoreboard: mirror of the class registers and slot table, queue of
    // expected results in the order items were taken
    // -----------------------------------------------------------------------
    class alloc_tracker;
        logic [BASE_W-1:0]  base_q  [CFG_CLASSES];
        logic [COUNT_W-1:0] count_q [CFG_CLASSES];
        int unsigned        in_use  [CFG_CLASSES];
        bit                 held    [SLOTS];
        logic [JOB_W-1:0]   owner   [SLOTS];
        t_res               expected_answers [$];
        int                 mismatches;

        function new();
            for (int c = 0; c < CFG_CLASSES; c++) begin
                base_q[c]  = BASE_RST[c];
                count_q[c] = COUNT_RST[c];
                in_use[c]  = 0;
            end
            for (int s = 0; s < SLOTS; s++) begin
                held[s]  = 1'b0;
                owner[s] = '0;
            end
            mismatches = 0;
        endfunction

        function int pending();
            return expected_answers.size();
        endfunction

        // class register write; indexes past the last class are dropped
        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx >= REG_COUNT)
                return;
            if (idx[0] == 1'b0)
                base_q[idx[CLS_W:1]] = data[BASE_W-1:0];
            else
                count_q[idx[CLS_W:1]] = data;
        endfunction

        // free by count, floored at zero after a count shrinks below use
        function int unsigned free_left(int c);
            return (int'(count_q[c]) > in_use[c]) ? int'(count_q[c]) - in_use[c] : 0;
        endfunction

        function t_res allocate_or_reclaim(t_req r);
            t_res a;
            int   c;
            int   s;
            int   stop;
            int   pick;
            bit   hit;
            a    = '0;
            hit  = 1'b0;
            pick = 0;
            if (r.class_id >= CFG_CLASSES) begin
                a.status = ST_NO_CLASS;
                return a;
            end
            c    = int'(r.class_id);
            stop = int'(base_q[c]) + int'(count_q[c]);
            if (stop > SLOTS)
                stop = SLOTS;
            if (r.kind == KIND_ALLOC) begin
                if (free_left(c) >= 1) begin
                    for (s = int'(base_q[c]); s < stop; s++)
                        if (!hit && !held[s]) begin
                            hit  = 1'b1;
                            pick = s;
                        end
                end
                if (hit) begin
                    held[pick]  = 1'b1;
                    owner[pick] = r.job_tag;
                    if (in_use[c] < 31)
                        in_use[c]++;
                    a.status        = ST_ALLOCATED;
                    a.device_number = pick[DEV_W-1:0];
                end else begin
                    a.status = ST_NONE_FREE;
                end
            end else begin
                for (s = int'(base_q[c]); s < stop; s++)
                    if (!hit && held[s] && owner[s] == r.job_tag) begin
                        hit  = 1'b1;
                        pick = s;
                    end
                if (hit) begin
                    held[pick]  = 1'b0;
                    owner[pick] = '0;
                    if (in_use[c] > 0)
                        in_use[c]--;
                    a.status        = ST_RECLAIMED;
                    a.device_number = pick[DEV_W-1:0];
                end else begin
                    a.status = ST_NOT_HELD;
                end
            end
            a.class_free = COUNT_W'(free_left(c));
            return a;
        endfunction

        function void note_request(t_req r);
            expected_answers.push_back(allocate_or_reclaim(r));
        endfunction

        function void check_answer(t_res got);
            t_res want;
            if (expected_answers.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result: status %0d device %0d free %0d",
                             got.status, got.device_number, got.class_free);
                return;
            end
            want = expected_answers.pop_front();
            if (got.status !== want.status || got.device_number !== want.device_number ||
                got.class_free !== want.class_free) begin
                mismatches++;
                // values as status/device/free
                if (mismatches <= REPORT_LIMIT)
                    $display("result mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                             want.status, want.device_number, want.class_free,
                             got.status, got.device_number, got.class_free);
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    t_req                  i_item;
    logic                  busy;
    logic                  o_result_valid;
    t_res                  o_result;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    int unsigned      cycle_count = 0;
    logic [JOB_W-1:0] job_pool [POOL_SIZE];
    alloc_tracker     tracker;

    device_class_allocator #(
        .NUM_SLOTS(SLOTS)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .i_item         (i_item),
        .busy           (busy),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // hard stop if the block hangs
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // results last one cycle and cannot be stalled, so check every strobe
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid)
            tracker.check_answer(o_result);
    end

    // -----------------------------------------------------------------------
    // drivers: everything changes at the falling edge, handshakes are read at
    // the rising edge
    // -----------------------------------------------------------------------

    // hold start until the block takes the item; returns at the next falling
    // edge with start still high so back-to-back items need no reassignment
    task automatic issue_request(input t_req r);
        start  = 1'b1;
        i_item = r;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        tracker.note_request(r);
        @(negedge i_clk);
    endtask

    // idle gap after an item: mostly none or short, now and then long;
    // the item bus carries noise while start is low
    task automatic idle_gap(input bit bursty);
        int roll;
        int n;
        roll = $urandom_range(0, 99);
        if (bursty || roll < 50)
            n = 0;
        else if (roll < 85)
            n = $urandom_range(1, 3);
        else if (roll < 97)
            n = $urandom_range(4, 12);
        else
            n = $urandom_range(20, 60);
        if (n > 0) begin
            start  = 1'b0;
            i_item = t_req'($urandom);
            repeat (n) @(negedge i_clk);
        end
    endtask

    task automatic send(input t_req r, input bit bursty);
        issue_request(r);
        idle_gap(bursty);
    endtask

    task automatic write_reg(input int idx, input int value);
        i_cfg_valid = 1'b1;
        i_cfg_index = CFG_IDX_W'(idx);
        i_cfg_data  = CFG_DATA_W'(value);
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        tracker.write_reg(i_cfg_index, i_cfg_data);
        @(negedge i_clk);
    endtask

    // only touch the class registers with nothing in flight
    task automatic wait_idle();
        start = 1'b0;
        while (tracker.pending() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // first phases use the hand-picked maps, later ones random maps with
    // empty and full-size classes mixed in
    task automatic load_class_map(input int phase);
        int b;
        int n;
        int roll;
        for (int c = 0; c < CFG_CLASSES; c++) begin
            if (phase < 2) begin
                b = EXT_BASE[phase][c];
                n = EXT_COUNT[phase][c];
            end else begin
                b    = $urandom_range(0, SLOTS - 1);
                roll = $urandom_range(0, 9);
                n    = (roll == 0) ? 0 : (roll == 1) ? SLOTS : $urandom_range(1, 6);
            end
            write_reg(2 * c, b);
            write_reg(2 * c + 1, n);
        end
        // write past the last register, must be ignored
        write_reg($urandom_range(REG_COUNT, 2 ** CFG_IDX_W - 1), $urandom_range(0, 31));
        i_cfg_valid = 1'b0;
    endtask

    function automatic t_req make_req(logic kind, int cls, int job, int rel);
        t_req r;
        r.kind            = kind;
        r.class_id        = 3'(cls);
        r.job_tag         = JOB_W'(job);
        r.relative_number = REL_W'(rel);
        return r;
    endfunction

    // mostly known classes and pooled jobs so reclaims find their slots;
    // the rest is unknown classes and stray jobs
    function automatic t_req random_req();
        t_req r;
        r.kind     = ($urandom_range(0, 99) < 55) ? KIND_ALLOC : KIND_RECLAIM;
        r.class_id = ($urandom_range(0, 99) < 8) ? 3'($urandom_range(4, 7))
                                                 : 3'($urandom_range(0, 3));
        r.job_tag  = ($urandom_range(0, 99) < 85) ? job_pool[$urandom_range(0, POOL_SIZE - 1)]
                                                  : JOB_W'($urandom);
        r.relative_number = REL_W'($urandom);
        return r;
    endfunction

    initial begin
        bit bursty;
        tracker     = new();
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_item      = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        for (int k = 0; k < POOL_SIZE; k++)
            job_pool[k] = JOB_W'($urandom);
        repeat (RST_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed items on the reset map: class 0 = slots 0..1,
        // class 1 = 2..4, class 2 = 5..8, class 3 = slot 9
        send(make_req(KIND_ALLOC,   0, 16'h0000, 8'h00), 1'b0);
        send(make_req(KIND_ALLOC,   0, 16'hFFFF, 8'hFF), 1'b0);
        send(make_req(KIND_ALLOC,   0, 16'h1234, 8'h5A), 1'b0);  // class full
        send(make_req(KIND_RECLAIM, 0, 16'h5555, 8'h00), 1'b0);  // job holds none
        send(make_req(KIND_RECLAIM, 0, 16'h0000, 8'h00), 1'b0);
        // freed slot has tag zero but is not allocated
        send(make_req(KIND_RECLAIM, 0, 16'h0000, 8'h00), 1'b0);
        send(make_req(KIND_ALLOC,   3, 16'hAAAA, 8'h55), 1'b0);
        send(make_req(KIND_ALLOC,   3, 16'hAAAA, 8'hAA), 1'b0);
        send(make_req(KIND_RECLAIM, 3, 16'hAAAA, 8'h00), 1'b0);
        // unknown classes, both kinds
        send(make_req(KIND_ALLOC,   4, 16'h0F0F, 8'h0F), 1'b0);
        send(make_req(KIND_RECLAIM, 7, 16'hFFFF, 8'hFF), 1'b0);
        send(make_req(KIND_ALLOC,   5, 16'hF0F0, 8'hF0), 1'b0);
        send(make_req(KIND_RECLAIM, 6, 16'h0000, 8'h00), 1'b0);
        // one job holding two slots in a class, reclaimed first-slot first
        send(make_req(KIND_ALLOC,   1, 16'h0001, 8'h01), 1'b0);
        send(make_req(KIND_ALLOC,   1, 16'h0002, 8'h02), 1'b0);
        send(make_req(KIND_ALLOC,   1, 16'h0001, 8'h03), 1'b0);
        send(make_req(KIND_ALLOC,   1, 16'h0003, 8'h04), 1'b0);
        send(make_req(KIND_RECLAIM, 1, 16'h0001, 8'h00), 1'b0);
        send(make_req(KIND_RECLAIM, 1, 16'h0001, 8'h00), 1'b0);
        // job holds a slot, but in another class
        send(make_req(KIND_RECLAIM, 2, 16'hFFFF, 8'h00), 1'b0);
        send(make_req(KIND_ALLOC,   2, 16'h8000, 8'h80), 1'b0);
        send(make_req(KIND_RECLAIM, 0, 16'hFFFF, 8'h00), 1'b0);

        // random phases; slot ownership carries across map changes so
        // shrunk counts and overlapping ranges meet stale allocations
        for (int phase = 0; phase < PHASES; phase++) begin
            wait_idle();
            load_class_map(phase);
            bursty = (phase % 4 == 3);
            for (int k = 0; k < ITEMS_PER_PHASE; k++)
                send(random_req(), bursty);
        end

        start = 1'b0;
        while (tracker.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
